// ----- hw/rtl/i2c_register_access_sequencer_defines.svh -----
// Assertion macros shared by the sequencer checker
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define I2CRAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define I2CRAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/i2cras_pkg.sv -----
// Types and codes of the I2C register access sequencer
package i2cras_pkg;

    localparam int unsigned BYTE_W = 8;

    // request types
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;

    // engine commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_RECV  = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    // error codes reported with the final stop
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_ADDR_WR_NAK = 3'd1;
    localparam logic [2:0] ERR_REG_NAK     = 3'd2;
    localparam logic [2:0] ERR_DATA_NAK    = 3'd3;
    localparam logic [2:0] ERR_ADDR_RD_NAK = 3'd4;

    // engine status codes that abort
    localparam logic [BYTE_W-1:0] ST_ADDR_NACK    = 8'h20;
    localparam logic [BYTE_W-1:0] ST_DATA_NACK    = 8'h30;
    localparam logic [BYTE_W-1:0] ST_ADDR_RD_NACK = 8'h48;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [BYTE_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] wr_data;
        logic [BYTE_W-1:0] bus_status;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic [2:0]        cmd;
        logic [BYTE_W-1:0] cmd_byte;
        logic              done_res;
        logic [2:0]        error_code;
        logic [BYTE_W-1:0] rd_data;
    } t_res;

endpackage

// ----- hw/rtl/i2cras_in_stage.sv -----
// Input register stage with valid/stall handshake
module i2cras_in_stage import i2cras_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_item i_item,
    input  logic  i_adv,
    output logic  o_in_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // held item can only leave when the result side advances
    assign o_in_stall = r_valid && !i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hw/rtl/i2cras_seq.sv -----
// Transaction phase machine: one item per cycle, yields zero or one command
module i2cras_seq import i2cras_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_item i_item,
    output t_res  o_res
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_ADDR    = 3'd2,
        PH_REG     = 3'd3,
        PH_DATA    = 3'd4,
        PH_RSTART  = 3'd5,
        PH_ADDR_RD = 3'd6,
        PH_RX      = 3'd7
    } t_phase;

    t_phase            r_phase,   n_phase;
    logic              r_is_read, n_is_read;
    logic [BYTE_W-1:0] r_dev,     n_dev;
    logic [BYTE_W-1:0] r_reg,     n_reg;
    logic [BYTE_W-1:0] r_wr,      n_wr;
    t_res              res;

    always_comb begin
        n_phase   = r_phase;
        n_is_read = r_is_read;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_wr      = r_wr;
        res       = '0;

        if (i_fire) begin
            case (i_item.req_type)
                REQ_WRITE, REQ_READ: begin
                    // requests while busy are dropped
                    if (r_phase == PH_IDLE) begin
                        n_is_read = (i_item.req_type == REQ_READ);
                        n_dev     = i_item.dev_addr;
                        n_reg     = i_item.reg_addr;
                        n_wr      = i_item.wr_data;
                        n_phase   = PH_START;
                        res.valid = 1'b1;
                        res.cmd   = CMD_START;
                    end
                end
                REQ_EVENT: begin
                    res.valid = (r_phase != PH_IDLE);
                    case (r_phase)
                        PH_START: begin
                            n_phase      = PH_ADDR;
                            res.cmd      = CMD_SEND;
                            res.cmd_byte = r_dev ^ {{(BYTE_W-1){1'b0}}, r_is_read};
                        end
                        PH_ADDR: begin
                            if (i_item.bus_status == ST_ADDR_NACK) begin
                                n_phase        = PH_IDLE;
                                res.cmd        = CMD_STOP;
                                res.done_res   = 1'b1;
                                res.error_code = ERR_ADDR_WR_NAK;
                            end else begin
                                n_phase      = PH_REG;
                                res.cmd      = CMD_SEND;
                                res.cmd_byte = r_reg;
                            end
                        end
                        PH_REG: begin
                            if (i_item.bus_status == ST_DATA_NACK) begin
                                n_phase        = PH_IDLE;
                                res.cmd        = CMD_STOP;
                                res.done_res   = 1'b1;
                                res.error_code = ERR_REG_NAK;
                            end else if (r_is_read) begin
                                n_phase = PH_RSTART;
                                res.cmd = CMD_START;
                            end else begin
                                n_phase      = PH_DATA;
                                res.cmd      = CMD_SEND;
                                res.cmd_byte = r_wr;
                            end
                        end
                        PH_DATA: begin
                            n_phase      = PH_IDLE;
                            res.cmd      = CMD_STOP;
                            res.done_res = 1'b1;
                            if (i_item.bus_status == ST_DATA_NACK) begin
                                res.error_code = ERR_DATA_NAK;
                            end
                        end
                        PH_RSTART: begin
                            n_phase      = PH_ADDR_RD;
                            res.cmd      = CMD_SEND;
                            res.cmd_byte = r_dev;
                        end
                        PH_ADDR_RD: begin
                            if (i_item.bus_status == ST_ADDR_RD_NACK) begin
                                n_phase        = PH_IDLE;
                                res.cmd        = CMD_STOP;
                                res.done_res   = 1'b1;
                                res.error_code = ERR_ADDR_RD_NAK;
                            end else begin
                                n_phase = PH_RX;
                                res.cmd = CMD_RECV;
                            end
                        end
                        PH_RX: begin
                            n_phase      = PH_IDLE;
                            res.cmd      = CMD_STOP;
                            res.done_res = 1'b1;
                            res.rd_data  = i_item.rx_byte;
                        end
                        default: begin
                            // idle: events are dropped
                            res.valid = 1'b0;
                        end
                    endcase
                end
                default: begin
                    // unused request code: no effect
                    res.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_read <= 1'b0;
            r_dev     <= '0;
            r_reg     <= '0;
            r_wr      <= '0;
        end else begin
            r_phase   <= n_phase;
            r_is_read <= n_is_read;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_wr      <= n_wr;
        end
    end

    assign o_res = res;

endmodule

// ----- hw/rtl/i2cras_out_stage.sv -----
// Result register with valid/stall handshake
module i2cras_out_stage import i2cras_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_res i_res,
    input  logic i_out_stall,
    output logic o_adv,
    output t_res o_res
);

    logic r_valid;
    t_res r_res;

    // register free or being emptied this cycle
    assign o_adv = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_res.valid) begin
            r_res <= i_res;
        end
    end

    always_comb begin
        o_res       = r_res;
        o_res.valid = r_valid;
    end

endmodule

// ----- hw/rtl/i2c_register_access_sequencer.sv -----
// Top level of the I2C register access sequencer
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+---------------------------------------------
//  input   | i_in_valid | o_in_stall  | i_req_type i_dev_addr i_reg_addr i_wr_data
//          |            |             | i_bus_status i_rx_byte
//  result  | o_out_valid| i_out_stall | o_cmd o_cmd_byte o_done_res o_error_code
//          |            |             | o_rd_data
//
// One item per clock sustained while the result side is not stalled. Two register
// stages: the input register captures the item, then the result register loads the
// result the phase machine makes from it once the result side can advance.
// Synchronous active-low reset clears the phase machine and both valid flags.
// A stalled result holds; the input side stalls only while the input register holds
// an item and the result register is full and stalled. Items that give no result
// (request while busy, event while idle, unused request code) still pass through
// both stages.
module i2c_register_access_sequencer import i2cras_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [BYTE_W-1:0] i_dev_addr,
    input  logic [BYTE_W-1:0] i_reg_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic [BYTE_W-1:0] i_bus_status,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_cmd,
    output logic [BYTE_W-1:0] o_cmd_byte,
    output logic              o_done_res,
    output logic [2:0]        o_error_code,
    output logic [BYTE_W-1:0] o_rd_data
);

    t_item in_item;
    t_item held_item;
    logic  held_valid;
    logic  adv;
    t_res  seq_res;
    t_res  out_res;

    always_comb begin
        in_item.req_type   = i_req_type;
        in_item.dev_addr   = i_dev_addr;
        in_item.reg_addr   = i_reg_addr;
        in_item.wr_data    = i_wr_data;
        in_item.bus_status = i_bus_status;
        in_item.rx_byte    = i_rx_byte;
    end

    // stage 1: capture the item
    i2cras_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (in_item),
        .i_adv      (adv),
        .o_in_stall (o_in_stall),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    // phase machine acts on the held item only when the result slot can take it,
    // so state moves exactly once per item and in arrival order
    i2cras_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (held_valid && adv),
        .i_item  (held_item),
        .o_res   (seq_res)
    );

    // stage 2: result register toward the byte engine
    i2cras_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (seq_res),
        .i_out_stall (i_out_stall),
        .o_adv       (adv),
        .o_res       (out_res)
    );

    assign o_out_valid  = out_res.valid;
    assign o_cmd        = out_res.cmd;
    assign o_cmd_byte   = out_res.cmd_byte;
    assign o_done_res   = out_res.done_res;
    assign o_error_code = out_res.error_code;
    assign o_rd_data    = out_res.rd_data;

endmodule

// ----- hw/rtl/i2cras_chk.sv -----
// Port-level checker for the sequencer, bound to the top level
`include "i2c_register_access_sequencer_defines.svh"

module i2cras_chk import i2cras_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [1:0]        i_req_type,
    input logic [BYTE_W-1:0] i_dev_addr,
    input logic [BYTE_W-1:0] i_reg_addr,
    input logic [BYTE_W-1:0] i_wr_data,
    input logic [BYTE_W-1:0] i_bus_status,
    input logic [BYTE_W-1:0] i_rx_byte,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [2:0]        o_cmd,
    input logic [BYTE_W-1:0] o_cmd_byte,
    input logic              o_done_res,
    input logic [2:0]        o_error_code,
    input logic [BYTE_W-1:0] o_rd_data
);

    `I2CRAS_ASSERT_NOW(a_done_on_stop, o_out_valid && o_done_res, o_cmd == CMD_STOP, "done without stop")
    `I2CRAS_ASSERT_NOW(a_stop_is_done, o_out_valid && o_cmd == CMD_STOP, o_done_res && (o_error_code == ERR_OK || o_rd_data == '0), "stop result fields inconsistent")
    `I2CRAS_ASSERT_NOW(a_plain_fields, o_out_valid && o_cmd != CMD_STOP, o_error_code == ERR_OK && o_rd_data == '0 && (o_cmd == CMD_SEND || o_cmd_byte == '0) && o_cmd != CMD_NONE, "non-stop result fields not clean")
    `I2CRAS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_cmd) && $stable(o_cmd_byte) && $stable(o_rd_data), "stalled result changed")

endmodule

bind i2c_register_access_sequencer i2cras_chk u_chk (.*);
